FILE: src/hcm_pkg.sv
`default_nettype none
package hcm_pkg;

  localparam int SampleW = 16;
  localparam int TolW    = 17;
  localparam int NumW    = 19;  // holds 6 * delta for 16-bit samples
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 17;

  localparam logic [CfgIdxW-1:0] CfgMaskRed   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaskGreen = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaskBlue  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTolerance = 2'd3;

  localparam logic [SampleW-1:0] MaskReset = 16'd255;
  localparam logic [TolW-1:0]    TolReset  = 17'd6554;

  // what travels alongside the hue division
  typedef struct packed {
    logic [SampleW-1:0] red;
    logic [SampleW-1:0] green;
    logic [SampleW-1:0] blue;
    logic               decided;
    logic               dec_masked;
    logic [TolW-1:0]    tol;
  } hcm_side_t;

  typedef struct packed {
    hcm_side_t       side;
    logic [NumW-1:0] num_p;
    logic [NumW-1:0] div_p;
    logic [NumW-1:0] num_m;
    logic [NumW-1:0] div_m;
  } hcm_item_t;

endpackage
`default_nettype wire

FILE: src/hsv_color_mask_pixel.sv
`default_nettype none
// color-key mask on one rgb pixel per beat
//
// input: a pixel is taken at a rising edge with start high and busy low.
// output: each pixel yields one result, shown for one cycle with valid_o
// high; the receiver cannot hold it off and must take it then.
// configuration: cfg_valid_i / cfg_ready_o carry a register index and data;
// index 0..2 is the mask red, green, blue sample, 3 the tolerance, others
// are dropped. write only while no pixel is in flight.
// path from accept to result: front register, queue, one division stage per
// hue bit, then the final compare and output register.
// throughput: one pixel per cycle; the hue dividers are fully pipelined,
// so busy stays low in normal operation.
// reset: all pipeline valids clear, mask returns to 255,255,255 and
// tolerance to 6554; no pixel is in flight afterwards.
module hsv_color_mask_pixel #(
  parameter int FULL_SCALE    = 65535,
  parameter int HUE_FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [hcm_pkg::SampleW-1:0]   pixel_red_i,
  input  wire logic [hcm_pkg::SampleW-1:0]   pixel_green_i,
  input  wire logic [hcm_pkg::SampleW-1:0]   pixel_blue_i,
  output logic                               valid_o,
  output logic [hcm_pkg::SampleW-1:0]        out_red_o,
  output logic [hcm_pkg::SampleW-1:0]        out_green_o,
  output logic [hcm_pkg::SampleW-1:0]        out_blue_o,
  output logic                               masked_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hcm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [hcm_pkg::CfgW-1:0]      cfg_data_i
);
  import hcm_pkg::*;

  logic [SampleW-1:0] mask_red_q, mask_green_q, mask_blue_q;
  logic [TolW-1:0]    tol_q;
  logic               cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_red_q   <= MaskReset;
      mask_green_q <= MaskReset;
      mask_blue_q  <= MaskReset;
      tol_q        <= TolReset;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CfgMaskRed:   mask_red_q   <= cfg_data_i[SampleW-1:0];
        CfgMaskGreen: mask_green_q <= cfg_data_i[SampleW-1:0];
        CfgMaskBlue:  mask_blue_q  <= cfg_data_i[SampleW-1:0];
        CfgTolerance: tol_q        <= cfg_data_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  logic      push, front_vld, q_vld, q_full;
  hcm_item_t front_item, q_item;

  assign push = start && !busy;
  assign busy = q_full;

  hcm_front #(.FULL_SCALE(FULL_SCALE)) u_front (
    .clk_i, .rst_ni,
    .push_i        (push),
    .pixel_red_i, .pixel_green_i, .pixel_blue_i,
    .mask_red_i    (mask_red_q),
    .mask_green_i  (mask_green_q),
    .mask_blue_i   (mask_blue_q),
    .tol_i         (tol_q),
    .valid_o       (front_vld),
    .item_o        (front_item)
  );

  hcm_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (front_vld),
    .item_i  (front_item),
    .valid_o (q_vld),
    .item_o  (q_item),
    .full_o  (q_full)
  );

  hcm_back #(.FULL_SCALE(FULL_SCALE), .HUE_FRAC_BITS(HUE_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i (q_vld),
    .item_i  (q_item),
    .valid_o, .out_red_o, .out_green_o, .out_blue_o, .masked_o
  );

endmodule
`default_nettype wire

FILE: src/hcm_front.sv
`default_nettype none
module hcm_front #(
  parameter int FULL_SCALE = 65535
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire logic [hcm_pkg::SampleW-1:0] pixel_red_i,
  input  wire logic [hcm_pkg::SampleW-1:0] pixel_green_i,
  input  wire logic [hcm_pkg::SampleW-1:0] pixel_blue_i,
  input  wire logic [hcm_pkg::SampleW-1:0] mask_red_i,
  input  wire logic [hcm_pkg::SampleW-1:0] mask_green_i,
  input  wire logic [hcm_pkg::SampleW-1:0] mask_blue_i,
  input  wire logic [hcm_pkg::TolW-1:0]    tol_i,
  output logic                           valid_o,
  output hcm_pkg::hcm_item_t             item_o
);
  import hcm_pkg::*;

  localparam logic [SampleW-1:0] FullScale = SampleW'(FULL_SCALE);

  function automatic logic [SampleW-1:0] max3(input logic [SampleW-1:0] a,
      input logic [SampleW-1:0] b, input logic [SampleW-1:0] c);
    logic [SampleW-1:0] m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

  function automatic logic [SampleW-1:0] min3(input logic [SampleW-1:0] a,
      input logic [SampleW-1:0] b, input logic [SampleW-1:0] c);
    logic [SampleW-1:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

  // hue numerator, always in [0, 6d)
  function automatic logic [NumW-1:0] hue_num(input logic [SampleW-1:0] r,
      input logic [SampleW-1:0] g, input logic [SampleW-1:0] b,
      input logic [SampleW-1:0] mx, input logic [SampleW-1:0] d);
    logic signed [NumW+1:0] n;
    logic signed [NumW+1:0] sd;
    logic signed [NumW+1:0] rs;
    logic signed [NumW+1:0] gs;
    logic signed [NumW+1:0] bs;
    sd = signed'((NumW+2)'(d));
    rs = signed'((NumW+2)'(r));
    gs = signed'((NumW+2)'(g));
    bs = signed'((NumW+2)'(b));
    if (r == mx) begin
      n = gs - bs;
      if (n < 0) n = n + (sd <<< 2) + (sd <<< 1);
    end else if (g == mx) begin
      n = (sd <<< 1) + bs - rs;
    end else begin
      n = (sd <<< 2) + rs - gs;
    end
    return n[NumW-1:0];
  endfunction

  logic [SampleW-1:0] pmx, pmn, pd, mmx, mmn, md;
  logic [33:0]        sat_lhs, sat_rhs;
  hcm_item_t          item_d;

  always_comb begin
    pmx = max3(pixel_red_i, pixel_green_i, pixel_blue_i);
    pmn = min3(pixel_red_i, pixel_green_i, pixel_blue_i);
    mmx = max3(mask_red_i, mask_green_i, mask_blue_i);
    mmn = min3(mask_red_i, mask_green_i, mask_blue_i);
    pd  = pmx - pmn;
    md  = mmx - mmn;
    sat_lhs = {2'b00, pd, 16'h0000};
    sat_rhs = 34'(tol_i) * 34'(FullScale);

    item_d.side.red        = pixel_red_i;
    item_d.side.green      = pixel_green_i;
    item_d.side.blue       = pixel_blue_i;
    item_d.side.tol        = tol_i;
    item_d.side.decided    = 1'b1;
    item_d.side.dec_masked = 1'b0;
    priority if (pmx > mmx) begin
      item_d.side.dec_masked = 1'b1;
    end else if (pmx == '0 || pd == '0) begin
      item_d.side.dec_masked = 1'b0;
    end else if (md == '0) begin
      item_d.side.dec_masked = (sat_lhs >= sat_rhs);
    end else begin
      item_d.side.decided = 1'b0;
    end
    item_d.num_p = hue_num(pixel_red_i, pixel_green_i, pixel_blue_i, pmx, pd);
    item_d.div_p = NumW'({pd, 2'b00}) + NumW'({pd, 1'b0});
    item_d.num_m = hue_num(mask_red_i, mask_green_i, mask_blue_i, mmx, md);
    item_d.div_m = NumW'({md, 2'b00}) + NumW'({md, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) item_o <= item_d;
  end

endmodule
`default_nettype wire

FILE: src/hcm_fifo.sv
`default_nettype none
module hcm_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  hcm_pkg::hcm_item_t item_i,
  output logic               valid_o,
  output hcm_pkg::hcm_item_t item_o,
  output logic               full_o
);
  import hcm_pkg::*;

  hcm_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  // the back end takes a beat every cycle one is present
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule
`default_nettype wire

FILE: src/hcm_back.sv
`default_nettype none
module hcm_back #(
  parameter int FULL_SCALE    = 65535,
  parameter int HUE_FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  hcm_pkg::hcm_item_t               item_i,
  output logic                             valid_o,
  output logic [hcm_pkg::SampleW-1:0]      out_red_o,
  output logic [hcm_pkg::SampleW-1:0]      out_green_o,
  output logic [hcm_pkg::SampleW-1:0]      out_blue_o,
  output logic                             masked_o
);
  import hcm_pkg::*;

  localparam int F = HUE_FRAC_BITS;
  localparam logic [SampleW-1:0] FullScale = SampleW'(FULL_SCALE);

  // one quotient bit per stage for both hues
  logic            vld_q   [F];
  hcm_side_t       side_q  [F];
  logic [NumW-1:0] rem_p_q [F];
  logic [NumW-1:0] rem_m_q [F];
  logic [NumW-1:0] div_p_q [F];
  logic [NumW-1:0] div_m_q [F];
  logic [F-1:0]    q_p_q   [F];
  logic [F-1:0]    q_m_q   [F];

  for (genvar i = 0; i < F; i++) begin : g_div
    logic            vld_in;
    hcm_side_t       side_in;
    logic [NumW-1:0] rp_in, rm_in, dp_in, dm_in;
    logic [F-1:0]    qp_in, qm_in;
    logic [NumW:0]   tp, tm;
    logic            gep, gem;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign side_in = item_i.side;
      assign rp_in   = item_i.num_p;
      assign rm_in   = item_i.num_m;
      assign dp_in   = item_i.div_p;
      assign dm_in   = item_i.div_m;
      assign qp_in   = '0;
      assign qm_in   = '0;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign side_in = side_q[i-1];
      assign rp_in   = rem_p_q[i-1];
      assign rm_in   = rem_m_q[i-1];
      assign dp_in   = div_p_q[i-1];
      assign dm_in   = div_m_q[i-1];
      assign qp_in   = q_p_q[i-1];
      assign qm_in   = q_m_q[i-1];
    end

    assign tp  = {rp_in, 1'b0};
    assign tm  = {rm_in, 1'b0};
    assign gep = (tp >= {1'b0, dp_in});
    assign gem = (tm >= {1'b0, dm_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[i]  <= side_in;
      div_p_q[i] <= dp_in;
      div_m_q[i] <= dm_in;
      rem_p_q[i] <= gep ? NumW'(tp - {1'b0, dp_in}) : NumW'(tp);
      rem_m_q[i] <= gem ? NumW'(tm - {1'b0, dm_in}) : NumW'(tm);
      q_p_q[i]   <= {qp_in[F-2:0], gep};
      q_m_q[i]   <= {qm_in[F-2:0], gem};
    end
  end

  logic [F-1:0]   hp, hm, da_raw, da;
  logic [F+16:0]  lhs, rhs;
  logic           hue_off, masked_d;
  hcm_side_t      side_l;

  always_comb begin
    hp     = q_p_q[F-1];
    hm     = q_m_q[F-1];
    side_l = side_q[F-1];
    da_raw = (hp >= hm) ? hp - hm : hm - hp;
    // wrap to the short way round the circle
    da     = (da_raw > {1'b1, {(F-1){1'b0}}}) ? F'(0) - da_raw : da_raw;
    lhs    = {1'b0, da, 16'h0000};
    rhs    = {side_l.tol, {F{1'b0}}};
    hue_off  = (lhs > rhs);
    masked_d = side_l.decided ? side_l.dec_masked : hue_off;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vld_q[F-1];
    end
  end

  always_ff @(posedge clk_i) begin
    masked_o    <= masked_d;
    out_red_o   <= masked_d ? FullScale : side_l.red;
    out_green_o <= masked_d ? FullScale : side_l.green;
    out_blue_o  <= masked_d ? FullScale : side_l.blue;
  end

endmodule
`default_nettype wire
